>>> hdl/ssh_pkg.sv
// ----------------------------------------------------------------------------
// ssh_pkg
// Shared types, constants and helper functions for the servo setpoint
// conditioner.
// ----------------------------------------------------------------------------
package ssh_pkg;

   localparam int NUM_CH       = 4;
   localparam int FULL_SCALE   = 180;
   localparam int ADC_FULL     = 1023;
   localparam int ADC_SHIFT    = 10;

   localparam int CHAN_W       = 2;
   localparam int SAMPLE_W     = 10;
   localparam int ANGLE_W      = 8;
   localparam int QSTEP_W      = 6;
   localparam int DB_W         = 6;
   localparam int RAMP_W       = 8;
   localparam int CFG_IDX_W    = 2;
   localparam int CFG_DATA_W   = 8;

   localparam int CH_AW        = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
   localparam int ENTRY_W      = 2 * ANGLE_W;
   localparam int PROD_W       = SAMPLE_W + 8;
   localparam int DIV_STEPS    = ANGLE_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   localparam logic [QSTEP_W-1:0] RST_QUANT_STEP = QSTEP_W'(5);
   localparam logic [DB_W-1:0]    RST_DEADBAND   = DB_W'(3);
   localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE  = ANGLE_W'(180);
   localparam logic [RAMP_W-1:0]  RST_RAMP_STEP  = RAMP_W'(1);

   typedef enum logic [CFG_IDX_W-1:0] {
      REG_QUANT_STEP,
      REG_DEADBAND,
      REG_MAX_ANGLE,
      REG_RAMP_STEP
   } cfg_reg_type;

   typedef struct packed {
      logic [QSTEP_W-1:0] quant_step;
      logic [DB_W-1:0]    deadband;
      logic [ANGLE_W-1:0] max_angle;
      logic [RAMP_W-1:0]  ramp_step;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [ANGLE_W-1:0] dividend;
      logic [QSTEP_W-1:0] divisor;
   } rem_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [QSTEP_W-1:0] remainder;
   } rem_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_DIV,
      ST_SAMPLE_UPD,
      ST_TICK
   } state_type;

   function automatic logic [ANGLE_W-1:0] home_angle(input logic [CH_AW-1:0] ch);
      logic [ANGLE_W-1:0] a;
      unique case (int'(ch))
         0:       a = ANGLE_W'(80);
         1:       a = ANGLE_W'(120);
         2:       a = ANGLE_W'(60);
         3:       a = ANGLE_W'(180);
         default: a = '0;
      endcase
      return a;
   endfunction

   // reading * FULL_SCALE / 1023: estimate by /1024, one correction step
   function automatic logic [ANGLE_W-1:0] map_pos(input logic [SAMPLE_W-1:0] smp);
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] quo;
      logic [PROD_W-1:0] rem;
      prod = PROD_W'(smp) * PROD_W'(FULL_SCALE);
      quo  = prod >> ADC_SHIFT;
      rem  = prod - (quo << ADC_SHIFT) + quo;
      if (rem >= PROD_W'(ADC_FULL)) begin
         quo = quo + PROD_W'(1);
      end
      return ANGLE_W'(quo);
   endfunction

endpackage

>>> hdl/ssh_ram.sv
// ----------------------------------------------------------------------------
// ssh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4,
   parameter int AW    = 2
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ssh_rem.sv
// ----------------------------------------------------------------------------
// ssh_rem
// Iterative restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssh_rem (
   input  logic                 clock,
   input  logic                 reset,
   input  ssh_pkg::rem_req_type req,
   output ssh_pkg::rem_rsp_type rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [ssh_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ssh_pkg::QSTEP_W-1:0]     rem_ff, rem_in;
   logic [ssh_pkg::ANGLE_W-1:0]     dvd_ff, dvd_in;
   logic [ssh_pkg::QSTEP_W-1:0]     dsr_ff, dsr_in;
   logic [ssh_pkg::QSTEP_W:0]       trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   always_comb begin
      trial   = {rem_ff, dvd_ff[ssh_pkg::ANGLE_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = ssh_pkg::DIV_CNT_W'(ssh_pkg::DIV_STEPS);
         rem_in  = '0;
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = ssh_pkg::QSTEP_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = ssh_pkg::QSTEP_W'(trial);
         end
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - ssh_pkg::DIV_CNT_W'(1);
         if (cnt_ff == ssh_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign rsp.busy      = busy_ff;
   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("remainder unit restarted while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!busy_ff && $past(busy_ff)))
      else $error("remainder done without a finished run");

endmodule

>>> hdl/ssh_seq.sv
// ----------------------------------------------------------------------------
// ssh_seq
// Sequencer: read-modify-write of the per-channel target/drive RAM, sample
// quantisation with hysteresis, ramp step on tick, result register.
// ----------------------------------------------------------------------------
module ssh_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  ssh_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [ssh_pkg::CHAN_W-1:0]    req_channel,
   input  logic [ssh_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ssh_pkg::CHAN_W-1:0]    rsp_out_channel,
   output logic [ssh_pkg::ANGLE_W-1:0]   rsp_angle,
   output logic                          rsp_moving,
   output logic                          rsp_last
);

   localparam int AW = ssh_pkg::CH_AW;
   localparam int NA = ssh_pkg::ANGLE_W;

   ssh_pkg::state_type               state_ff, state_in;
   logic [AW-1:0]                    ch_ff, ch_in;
   logic [ssh_pkg::SAMPLE_W-1:0]     smp_ff, smp_in;
   logic [NA-1:0]                    pos_ff, pos_in;
   logic [ssh_pkg::NUM_CH-1:0]       valid_ff, valid_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ssh_pkg::CHAN_W-1:0]       rsp_ch_ff, rsp_ch_in;
   logic [NA-1:0]                    rsp_angle_ff, rsp_angle_in;
   logic                             rsp_moving_ff, rsp_moving_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             ram_we, ram_re;
   logic [AW-1:0]                    ram_waddr, ram_raddr;
   logic [ssh_pkg::ENTRY_W-1:0]      ram_wdata, ram_rdata, entry;

   ssh_pkg::rem_req_type             rem_req;
   ssh_pkg::rem_rsp_type             rem_rsp;

   logic [NA-1:0]                    cur_target, cur_drive;
   logic [ssh_pkg::QSTEP_W-1:0]      qstep;
   logic [ssh_pkg::RAMP_W-1:0]       rstep;
   logic [NA-1:0]                    qval, t_raw, t_new, d_new;
   logic                             go_up, go_down;
   logic                             out_free, last_ch;

   ssh_ram #(
      .WIDTH (ssh_pkg::ENTRY_W),
      .DEPTH (ssh_pkg::NUM_CH),
      .AW    (AW)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ssh_rem u_rem (
      .clock (clock),
      .reset (reset),
      .req   (rem_req),
      .rsp   (rem_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssh_pkg::ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         ch_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ch_ff        <= ch_in;
      end
      smp_ff        <= smp_in;
      pos_ff        <= pos_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_angle_ff  <= rsp_angle_in;
      rsp_moving_ff <= rsp_moving_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // entries never written read as the home position
   always_comb begin
      if (valid_ff[ch_ff]) begin
         entry = ram_rdata;
      end else begin
         entry = {ssh_pkg::home_angle(ch_ff), ssh_pkg::home_angle(ch_ff)};
      end
      cur_target = entry[ssh_pkg::ENTRY_W-1:NA];
      cur_drive  = entry[NA-1:0];
   end

   assign qstep = (cfg.quant_step == '0) ? ssh_pkg::QSTEP_W'(1) : cfg.quant_step;
   assign rstep = (cfg.ramp_step == '0) ? ssh_pkg::RAMP_W'(1) : cfg.ramp_step;

   // hysteresis on the quantised position, then clamp
   always_comb begin
      qval    = pos_ff - NA'(rem_rsp.remainder);
      go_up   = (qval > cur_target) &&
                ({1'b0, pos_ff} >= ({1'b0, qval} + (NA+1)'(cfg.deadband)));
      go_down = (qval < cur_target) &&
                (({1'b0, pos_ff} + (NA+1)'(cfg.deadband)) <= {1'b0, cur_target});
      t_raw   = (go_up || go_down) ? qval : cur_target;
      t_new   = (t_raw > cfg.max_angle) ? cfg.max_angle : t_raw;
   end

   // ramp one step toward the target
   always_comb begin
      d_new = cur_drive;
      if (cur_drive < cur_target) begin
         d_new = ((cur_target - cur_drive) > NA'(rstep)) ? cur_drive + NA'(rstep)
                                                          : cur_target;
      end else if (cur_drive > cur_target) begin
         d_new = ((cur_drive - cur_target) > NA'(rstep)) ? cur_drive - NA'(rstep)
                                                          : cur_target;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last_ch  = (ch_ff == AW'(ssh_pkg::NUM_CH - 1));

   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      smp_in        = smp_ff;
      pos_in        = pos_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_ch_in     = rsp_ch_ff;
      rsp_angle_in  = rsp_angle_ff;
      rsp_moving_in = rsp_moving_ff;
      rsp_last_in   = rsp_last_ff;
      req_ready     = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = ch_ff;
      ram_wdata     = entry;
      ram_re        = 1'b0;
      ram_raddr     = ch_ff;
      rem_req.start    = 1'b0;
      rem_req.dividend = ssh_pkg::map_pos(smp_ff);
      rem_req.divisor  = qstep;

      unique case (state_ff)
         ssh_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == ssh_pkg::KIND_TICK) begin
                  ram_re    = 1'b1;
                  ram_raddr = '0;
                  ch_in     = '0;
                  state_in  = ssh_pkg::ST_TICK;
               end else if (int'(req_channel) < ssh_pkg::NUM_CH) begin
                  ram_re    = 1'b1;
                  ram_raddr = AW'(req_channel);
                  ch_in     = AW'(req_channel);
                  smp_in    = req_sample;
                  state_in  = ssh_pkg::ST_MAP;
               end
            end
         end
         ssh_pkg::ST_MAP: begin
            rem_req.start = 1'b1;
            pos_in        = rem_req.dividend;
            state_in      = ssh_pkg::ST_DIV;
         end
         ssh_pkg::ST_DIV: begin
            if (rem_rsp.done) begin
               state_in = ssh_pkg::ST_SAMPLE_UPD;
            end
         end
         ssh_pkg::ST_SAMPLE_UPD: begin
            if (out_free) begin
               ram_we          = 1'b1;
               ram_wdata       = {t_new, cur_drive};
               valid_in[ch_ff] = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_ch_in       = ssh_pkg::CHAN_W'(ch_ff);
               rsp_angle_in    = t_new;
               rsp_moving_in   = (t_new != cur_drive);
               rsp_last_in     = 1'b1;
               state_in        = ssh_pkg::ST_IDLE;
            end
         end
         ssh_pkg::ST_TICK: begin
            if (out_free) begin
               ram_we          = 1'b1;
               ram_wdata       = {cur_target, d_new};
               valid_in[ch_ff] = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_ch_in       = ssh_pkg::CHAN_W'(ch_ff);
               rsp_angle_in    = d_new;
               rsp_moving_in   = (d_new != cur_target);
               rsp_last_in     = last_ch;
               if (last_ch) begin
                  state_in = ssh_pkg::ST_IDLE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = ch_ff + AW'(1);
                  ch_in     = ch_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = ssh_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_angle       = rsp_angle_ff;
   assign rsp_moving      = rsp_moving_ff;
   assign rsp_last        = rsp_last_ff;

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("RAM read and write hit the same entry");

   a_target_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssh_pkg::ST_SAMPLE_UPD && out_free) |-> (t_new <= cfg.max_angle))
      else $error("target above max angle");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      rem_rsp.done |-> (state_ff == ssh_pkg::ST_DIV))
      else $error("remainder result outside the divide wait");

endmodule

>>> hdl/servo_setpoint_hysteresis_slew.sv
// ----------------------------------------------------------------------------
// servo_setpoint_hysteresis_slew
// Four-channel servo setpoint conditioner: quantised target with hysteresis
// on samples, ramped drive angle on ticks.
// ----------------------------------------------------------------------------
// A sample transfer maps the reading to degrees, quantises it, applies the
// deadband and clamp, and presents one result with the new target; the next
// transfer is taken once that result is registered. The pace is set by the
// remainder unit, which produces one quotient bit per cycle for each bit of
// the dividend. A tick transfer presents one result per channel, one per
// cycle while the receiver keeps up, and the next transfer is taken once the
// last of them is registered; here the single write and read port of the
// state RAM sets the pace. Receiver stalls slow both kinds of transfer.
// One item is in work at a time; a waiting result does not stop the next
// transfer being taken once the current item has issued its last result.
// Configuration writes take effect immediately and belong in idle periods.
// ----------------------------------------------------------------------------
module servo_setpoint_hysteresis_slew (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [ssh_pkg::CHAN_W-1:0]     req_channel,
   input  logic [ssh_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ssh_pkg::CHAN_W-1:0]     rsp_out_channel,
   output logic [ssh_pkg::ANGLE_W-1:0]    rsp_angle,
   output logic                           rsp_moving,
   output logic                           rsp_last,
   input  logic                           csr_we,
   input  logic [ssh_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [ssh_pkg::CFG_DATA_W-1:0] csr_wdata
);

   ssh_pkg::cfg_type cfg_ff, cfg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quant_step <= ssh_pkg::RST_QUANT_STEP;
         cfg_ff.deadband   <= ssh_pkg::RST_DEADBAND;
         cfg_ff.max_angle  <= ssh_pkg::RST_MAX_ANGLE;
         cfg_ff.ramp_step  <= ssh_pkg::RST_RAMP_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (ssh_pkg::cfg_reg_type'(csr_index))
            ssh_pkg::REG_QUANT_STEP: cfg_in.quant_step = csr_wdata[ssh_pkg::QSTEP_W-1:0];
            ssh_pkg::REG_DEADBAND:   cfg_in.deadband   = csr_wdata[ssh_pkg::DB_W-1:0];
            ssh_pkg::REG_MAX_ANGLE:  cfg_in.max_angle  = csr_wdata[ssh_pkg::ANGLE_W-1:0];
            ssh_pkg::REG_RAMP_STEP:  cfg_in.ramp_step  = csr_wdata[ssh_pkg::RAMP_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   ssh_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_channel (rsp_out_channel),
      .rsp_angle       (rsp_angle),
      .rsp_moving      (rsp_moving),
      .rsp_last        (rsp_last)
   );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-channel servo setpoint conditioner. Sample
// and tick transfers are driven with random gaps and receiver stalls. A
// scoreboard class mirrors the quantiser, deadband, clamp and ramp, queues
// the expected results at each accepted transfer and compares every returned
// result field by field. Each phase starts once the block is idle and loads a
// new register setting.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int STALL_LIMIT = 2000;
   localparam logic [ssh_pkg::ANGLE_W-1:0] HOME [ssh_pkg::NUM_CH] =
      '{8'd80, 8'd120, 8'd60, 8'd180};

   typedef struct packed {
      logic [ssh_pkg::CHAN_W-1:0]  channel;
      logic [ssh_pkg::ANGLE_W-1:0] angle;
      logic                        moving;
      logic                        last;
   } servo_result_type;

   class setpoint_scoreboard;
      logic [ssh_pkg::QSTEP_W-1:0] quant_step;
      logic [ssh_pkg::DB_W-1:0]    deadband;
      logic [ssh_pkg::ANGLE_W-1:0] max_angle;
      logic [ssh_pkg::RAMP_W-1:0]  ramp_step;
      logic [ssh_pkg::ANGLE_W-1:0] target [ssh_pkg::NUM_CH];
      logic [ssh_pkg::ANGLE_W-1:0] drive [ssh_pkg::NUM_CH];
      servo_result_type            due_results [$];
      int                          n_errors;

      function new();
         quant_step = ssh_pkg::RST_QUANT_STEP;
         deadband   = ssh_pkg::RST_DEADBAND;
         max_angle  = ssh_pkg::RST_MAX_ANGLE;
         ramp_step  = ssh_pkg::RST_RAMP_STEP;
         n_errors   = 0;
         for (int i = 0; i < ssh_pkg::NUM_CH; i++) begin
            target[i] = HOME[i];
            drive[i]  = HOME[i];
         end
      endfunction

      function void write_reg(ssh_pkg::cfg_reg_type idx,
                              logic [ssh_pkg::CFG_DATA_W-1:0] data);
         case (idx)
            ssh_pkg::REG_QUANT_STEP: quant_step = data[ssh_pkg::QSTEP_W-1:0];
            ssh_pkg::REG_DEADBAND:   deadband   = data[ssh_pkg::DB_W-1:0];
            ssh_pkg::REG_MAX_ANGLE:  max_angle  = data[ssh_pkg::ANGLE_W-1:0];
            ssh_pkg::REG_RAMP_STEP:  ramp_step  = data[ssh_pkg::RAMP_W-1:0];
            default: ;
         endcase
      endfunction

      function bit idle();
         return due_results.size() == 0;
      endfunction

      // quantise with hysteresis on a sample, one ramp step on a tick
      function void note_transfer(logic kind, logic [ssh_pkg::CHAN_W-1:0] ch,
                                  logic [ssh_pkg::SAMPLE_W-1:0] smp);
         int               pos, q, step, t, prev, rs, d, tg;
         servo_result_type r;
         if (kind == ssh_pkg::KIND_SAMPLE) begin
            step = (quant_step == 0) ? 1 : int'(quant_step);
            pos  = int'(smp) * ssh_pkg::FULL_SCALE / ssh_pkg::ADC_FULL;
            q    = (pos / step) * step;
            prev = int'(target[ch]);
            t    = prev;
            if (q > prev && pos >= q + int'(deadband)) t = q;
            else if (q < prev && pos <= prev - int'(deadband)) t = q;
            if (t > int'(max_angle)) t = int'(max_angle);
            target[ch] = t[ssh_pkg::ANGLE_W-1:0];
            r = '{ch, target[ch], target[ch] != drive[ch], 1'b1};
            due_results.push_back(r);
         end else begin
            rs = (ramp_step == 0) ? 1 : int'(ramp_step);
            for (int i = 0; i < ssh_pkg::NUM_CH; i++) begin
               d  = int'(drive[i]);
               tg = int'(target[i]);
               if (d < tg) d = (tg - d > rs) ? d + rs : tg;
               else if (d > tg) d = (d - tg > rs) ? d - rs : tg;
               drive[i] = d[ssh_pkg::ANGLE_W-1:0];
               r = '{ssh_pkg::CHAN_W'(i), drive[i], d != tg, i == ssh_pkg::NUM_CH - 1};
               due_results.push_back(r);
            end
         end
      endfunction

      function void check_output(logic [ssh_pkg::CHAN_W-1:0] ch,
                                 logic [ssh_pkg::ANGLE_W-1:0] angle,
                                 logic moving, logic last);
         servo_result_type want;
         if (due_results.size() == 0) begin
            $error("unexpected result: channel %0d angle %0d", ch, angle);
            n_errors++;
            return;
         end
         want = due_results.pop_front();
         if (ch !== want.channel) begin
            $error("rsp_out_channel: expected %0d, actual %0d", want.channel, ch);
            n_errors++;
         end
         if (angle !== want.angle) begin
            $error("rsp_angle: expected %0d, actual %0d", want.angle, angle);
            n_errors++;
         end
         if (moving !== want.moving) begin
            $error("rsp_moving: expected %0d, actual %0d", want.moving, moving);
            n_errors++;
         end
         if (last !== want.last) begin
            $error("rsp_last: expected %0d, actual %0d", want.last, last);
            n_errors++;
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_kind = ssh_pkg::KIND_SAMPLE;
   logic [ssh_pkg::CHAN_W-1:0]     req_channel = '0;
   logic [ssh_pkg::SAMPLE_W-1:0]   req_sample = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [ssh_pkg::CHAN_W-1:0]     rsp_out_channel;
   logic [ssh_pkg::ANGLE_W-1:0]    rsp_angle;
   logic                           rsp_moving;
   logic                           rsp_last;
   logic                           csr_we = 1'b0;
   logic [ssh_pkg::CFG_IDX_W-1:0]  csr_index = '0;
   logic [ssh_pkg::CFG_DATA_W-1:0] csr_wdata = '0;

   setpoint_scoreboard             sb = new();
   int                             req_idle_pct = 33;
   int                             rsp_idle_pct = 71;
   int                             stall_cycles = 0;
   logic [ssh_pkg::SAMPLE_W-1:0]   last_reading [ssh_pkg::NUM_CH] = '{default: '0};

   servo_setpoint_hysteresis_slew uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_channel (rsp_out_channel),
      .rsp_angle       (rsp_angle),
      .rsp_moving      (rsp_moving),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_output(rsp_out_channel, rsp_angle, rsp_moving, rsp_last);
      end
   end

   // no transfer of any kind for too long means the block has hung
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // all tasks start and end on a falling edge
   task automatic send_item(logic kind, logic [ssh_pkg::CHAN_W-1:0] ch,
                            logic [ssh_pkg::SAMPLE_W-1:0] smp);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_channel <= ch;
      req_sample  <= smp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_transfer(kind, ch, smp);
      if (kind == ssh_pkg::KIND_SAMPLE) last_reading[ch] = smp;
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (!sb.idle()) @(negedge clock);
   endtask

   task automatic write_reg(ssh_pkg::cfg_reg_type idx,
                            logic [ssh_pkg::CFG_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic apply_config(logic [ssh_pkg::CFG_DATA_W-1:0] qs,
                               logic [ssh_pkg::CFG_DATA_W-1:0] db,
                               logic [ssh_pkg::CFG_DATA_W-1:0] mx,
                               logic [ssh_pkg::CFG_DATA_W-1:0] rs);
      write_reg(ssh_pkg::REG_QUANT_STEP, qs);
      write_reg(ssh_pkg::REG_DEADBAND, db);
      write_reg(ssh_pkg::REG_MAX_ANGLE, mx);
      write_reg(ssh_pkg::REG_RAMP_STEP, rs);
      csr_we <= 1'b0;
   endtask

   // mostly readings close to the channel's last one, to work the deadband
   task automatic random_block(int n);
      logic [ssh_pkg::CHAN_W-1:0] ch;
      int                         smp;
      for (int k = 0; k < n; k++) begin
         if (k == n / 2) wait_drain();
         ch = ssh_pkg::CHAN_W'($urandom_range(ssh_pkg::NUM_CH - 1));
         if ($urandom_range(99) < 30) begin
            send_item(ssh_pkg::KIND_TICK, ssh_pkg::CHAN_W'($urandom_range(3)),
                      ssh_pkg::SAMPLE_W'($urandom_range(1023)));
         end else if ($urandom_range(2) == 0) begin
            send_item(ssh_pkg::KIND_SAMPLE, ch, ssh_pkg::SAMPLE_W'($urandom_range(1023)));
         end else begin
            smp = int'(last_reading[ch]) + int'($urandom_range(24)) - 12;
            if (smp < 0) smp = 0;
            if (smp > 1023) smp = 1023;
            send_item(ssh_pkg::KIND_SAMPLE, ch, smp[ssh_pkg::SAMPLE_W-1:0]);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset setting: home angles, step 5, deadband 3
      send_item(ssh_pkg::KIND_TICK, 2'd0, 10'd0);
      send_item(ssh_pkg::KIND_SAMPLE, 2'd0, 10'd0);
      send_item(ssh_pkg::KIND_SAMPLE, 2'd1, 10'd1023);
      send_item(ssh_pkg::KIND_SAMPLE, 2'd2, 10'd1023);
      send_item(ssh_pkg::KIND_SAMPLE, 2'd3, 10'd0);
      send_item(ssh_pkg::KIND_SAMPLE, 2'd1, 10'd569);
      send_item(ssh_pkg::KIND_SAMPLE, 2'd1, 10'd586);
      send_item(ssh_pkg::KIND_SAMPLE, 2'd1, 10'd609);
      send_item(ssh_pkg::KIND_SAMPLE, 2'd1, 10'd614);
      send_item(ssh_pkg::KIND_SAMPLE, 2'd1, 10'd586);
      send_item(ssh_pkg::KIND_SAMPLE, 2'd1, 10'd581);
      send_item(ssh_pkg::KIND_TICK, 2'd3, 10'd1023);
      send_item(ssh_pkg::KIND_TICK, 2'd1, 10'd512);
      send_item(ssh_pkg::KIND_SAMPLE, 2'd0, 10'd1012);
      send_item(ssh_pkg::KIND_SAMPLE, 2'd2, 10'd1);
      send_item(ssh_pkg::KIND_SAMPLE, 2'd3, 10'd512);
      send_item(ssh_pkg::KIND_TICK, 2'd2, 10'd341);
      send_item(ssh_pkg::KIND_SAMPLE, 2'd2, 10'd682);
      send_item(ssh_pkg::KIND_TICK, 2'd0, 10'd0);

      for (int blk = 0; blk < 6; blk++) begin
         wait_drain();
         if (blk == 2) begin
            req_idle_pct = 71;
            rsp_idle_pct = 33;
         end else if (blk == 4) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         case (blk)
            0: apply_config(8'd1, 8'd0, 8'd255, 8'd255);
            1: apply_config(8'd45, 8'd44, 8'd180, 8'd180);
            2: apply_config(8'd0, 8'd63, 8'd0, 8'd0);
            3: apply_config(8'hFF, 8'hC1, 8'd100, 8'd3);
            4: apply_config(ssh_pkg::CFG_DATA_W'($urandom_range(1, 45)),
                            ssh_pkg::CFG_DATA_W'($urandom_range(44)),
                            ssh_pkg::CFG_DATA_W'($urandom_range(180)),
                            ssh_pkg::CFG_DATA_W'($urandom_range(1, 180)));
            default: apply_config(8'd5, 8'd3, 8'd180, 8'd1);
         endcase
         random_block(34);
      end

      wait_drain();
      repeat (20) @(posedge clock);
      if (sb.n_errors == 0 && sb.idle()) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
